FILE: src/pixel_to_splat_coalescer_unit_defines.svh
// Assertion macros for the pixel-to-splat coalescer checker.
// Included by the checker file only; no other dependencies.
`ifndef PIXEL_TO_SPLAT_COALESCER_UNIT_DEFINES_SVH
`define PIXEL_TO_SPLAT_COALESCER_UNIT_DEFINES_SVH

// same-cycle implication
`define P2S_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p2s checker: same-cycle property failed");

// next-cycle implication
`define P2S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p2s checker: next-cycle property failed");

`endif

FILE: src/p2s_pkg.sv
// Shared types, constants and the SH conversion for the pixel-to-splat coalescer.
// No dependencies; imported by every module of the block.
package p2s_pkg;

	localparam int CFG_DIM_W   = 11;
	localparam int COLOR_W     = 24;
	localparam int DEPTH_W     = 8;
	localparam int SH_W        = 14;
	localparam int POS_W       = 11;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 80;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	// Q.24 gain: 4096*sqrt(pi)/255
	localparam logic [36:0] SH_GAIN  = 37'd477655299;
	localparam logic [36:0] SH_ROUND = 37'd8388608;

	localparam logic [APB_ADDR_W-1:0] REG_FRAME_WIDTH  = 4'h0;
	localparam logic [APB_ADDR_W-1:0] REG_FRAME_HEIGHT = 4'h4;
	localparam logic [APB_ADDR_W-1:0] REG_USE_DEPTH    = 4'h8;

	localparam logic [CFG_DIM_W-1:0] FRAME_DIM_RESET = 11'd1024;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] frame_width;
		logic [CFG_DIM_W-1:0] frame_height;
		logic                 use_depth;
	} p2s_cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               kept;
		logic [DEPTH_W-1:0] depth;
	} p2s_line_entry_t;

	typedef struct packed {
		logic                   last_vertex;
		logic                   kept;
		logic                   tall_y;
		logic                   wide_x;
		logic signed [SH_W-1:0] sh_blue;
		logic signed [SH_W-1:0] sh_green;
		logic signed [SH_W-1:0] sh_red;
		logic [DEPTH_W-1:0]     pos_z;
		logic [POS_W-1:0]       pos_y_half;
		logic [POS_W-1:0]       pos_x_half;
	} p2s_result_t;

	// sign(m) * round(|m| * gain), m = 2c-255 (odd, never ties)
	function automatic logic signed [SH_W-1:0] sh_of(input logic [7:0] c);
		logic [8:0]      twice;
		logic [7:0]      mag;
		logic [36:0]     prod;
		logic [SH_W-1:0] q;
		twice = {c, 1'b0};
		mag   = c[7] ? 8'(twice - 9'd255) : 8'(9'd255 - twice);
		prod  = 37'(mag) * SH_GAIN + SH_ROUND;
		q     = {1'b0, prod[36:24]};
		return c[7] ? signed'(q) : signed'(-q);
	endfunction

endpackage

FILE: src/p2s_cfg_regs.sv
// APB register file: frame width, frame height, depth mode.
// Depends on p2s_pkg.
module p2s_cfg_regs
	import p2s_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output p2s_cfg_t              cfg
);

	p2s_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_DIM_RESET;
			cfg_q.frame_height <= FRAME_DIM_RESET;
			cfg_q.use_depth    <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[CFG_DIM_W-1:0];
				REG_USE_DEPTH:    cfg_q.use_depth    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_q.frame_height);
			REG_USE_DEPTH:    prdata = APB_DATA_W'(cfg_q.use_depth);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: src/p2s_line_ram.sv
// Line store: one write and one read port, registered read data,
// write-to-read bypass when both hit the same entry. Depends on p2s_pkg.
module p2s_line_ram
	import p2s_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int W     = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

endmodule

FILE: src/pixel_to_splat_coalescer_unit.sv
// Pixel-to-splat coalescer, top level: one pixel or flush item per clock in,
// one splat record out, through stage 1 and the result register, for the item that causes it.
// The block takes one item every clock while the result side keeps up: an item is
// registered together with its line-store read, the keep/merge decision and the
// SH conversion sit between that register and the result register. A pixel of
// row y produces the record of row y-1 in the same column; row 0 yields nothing,
// and after the last row one flush item per column drains the bottom row, the
// flush of the last column carrying tlast and restarting the frame. Pixel items
// after the last row and flush items before it are dropped without effect. The
// line stores do one read and one write per clock; they need no clearing.
module pixel_to_splat_coalescer_unit
	import p2s_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // red, green, blue, depth
	input  logic                   s_axis_tuser,  // mode (1 = flush)
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pos_x_half, pos_y_half, pos_z,
	                                              // sh_red, sh_green, sh_blue,
	                                              // wide_x, tall_y, zero pad
	output logic                   m_axis_tuser,  // kept
	output logic                   m_axis_tlast   // last_vertex
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP_W = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
	localparam int HCMP_W = (RW > CFG_DIM_W) ? RW : CFG_DIM_W;
	localparam int ENT_W  = $bits(p2s_line_entry_t);

	p2s_cfg_t cfg;

	// effective frame size
	logic [WCMP_W-1:0] w_raw;
	logic [HCMP_W-1:0] h_raw;
	logic [WW-1:0]     w_eff;
	logic [RW-1:0]     h_eff;

	// accept side
	logic          in_acc;
	logic          is_flush;
	logic          rows_done;
	logic          pix_ok;
	logic          flush_ok;
	logic          end_row;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// stage 1
	logic               s1_valid_q;
	logic               flush_s1;
	logic [CW-1:0]      x_s1;
	logic [RW-1:0]      yrow_s1;
	logic               end_row_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [DEPTH_W-1:0] depth_s1;
	logic               s1_adv;
	logic               s1_fire;

	logic               left_kept_q;
	logic [COLOR_W-1:0] left_color_q;

	// line stores
	logic [ENT_W-1:0]   ent_rdata;
	logic               ent_we;
	logic [ENT_W-1:0]   ent_wdata;
	logic [COLOR_W-1:0] right_rdata;
	logic [CW-1:0]      right_raddr;

	p2s_line_entry_t top;
	logic            top_same;
	logic            top_match;
	logic            left_hit;
	logic            kept_new;
	logic            coal;
	logic [POS_W-1:0] x11;
	logic [POS_W-1:0] y11;
	p2s_result_t     res_d;

	// stage 2 (result register)
	logic        s2_valid_q;
	p2s_result_t res_s2;

	p2s_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		w_raw = WCMP_W'(cfg.frame_width);
		h_raw = HCMP_W'(cfg.frame_height);
		if (w_raw == '0) begin
			w_eff = WW'(1);
		end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(w_raw);
		end
		if (h_raw == '0) begin
			h_eff = RW'(1);
		end else if (h_raw > HCMP_W'(MAX_HEIGHT)) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(h_raw);
		end
	end

	assign s1_adv        = !s2_valid_q || m_axis_tready;
	assign s1_fire       = s1_valid_q && s1_adv;
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign is_flush  = s_axis_tuser;
	assign rows_done = row_q >= h_eff;
	assign pix_ok    = !is_flush && !rows_done;
	assign flush_ok  = is_flush && rows_done;
	assign end_row   = (WW'(col_q) + WW'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc && (pix_ok || flush_ok)) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= is_flush ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= in_acc && (pix_ok || flush_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flush_s1   <= is_flush;
			x_s1       <= col_q;
			yrow_s1    <= is_flush ? h_eff - RW'(1) : row_q - RW'(1);
			end_row_s1 <= end_row;
			emit_s1    <= flush_ok || (row_q != '0);
			last_s1    <= is_flush && end_row;
			color_s1   <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
			depth_s1   <= s_axis_tdata[31:24];
		end
	end

	p2s_line_ram #(
		.DEPTH (MAX_WIDTH),
		.W     (ENT_W)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (x_s1),
		.wdata (ent_wdata),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (ent_rdata)
	);

	// copy of the stored row colors, read one column ahead for the right neighbor
	p2s_line_ram #(
		.DEPTH (MAX_WIDTH),
		.W     (COLOR_W)
	) u_right_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (x_s1),
		.wdata (color_s1),
		.re    (in_acc),
		.raddr (right_raddr),
		.rdata (right_rdata)
	);

	assign right_raddr = col_q + CW'(1);

	always_comb begin
		top       = p2s_line_entry_t'(ent_rdata);
		top_same  = top.color == color_s1;
		top_match = emit_s1 && top.kept && top_same;
		left_hit  = left_kept_q && (left_color_q == color_s1);
		kept_new  = cfg.use_depth || !(left_hit || top_match);
		coal      = top.kept && !cfg.use_depth;
		x11       = POS_W'(x_s1);
		y11       = POS_W'(yrow_s1);

		res_d.last_vertex = last_s1;
		res_d.kept        = top.kept;
		res_d.wide_x      = coal && !end_row_s1 && (right_rdata == top.color);
		res_d.tall_y      = coal && !flush_s1 && top_same;
		res_d.sh_red      = sh_of(top.color[23:16]);
		res_d.sh_green    = sh_of(top.color[15:8]);
		res_d.sh_blue     = sh_of(top.color[7:0]);
		res_d.pos_z       = cfg.use_depth ? top.depth : '0;
		res_d.pos_x_half  = {x11[POS_W-2:0], res_d.wide_x};
		res_d.pos_y_half  = {y11[POS_W-2:0], res_d.tall_y};
	end

	assign ent_we    = s1_fire && !flush_s1;
	assign ent_wdata = {color_s1, kept_new, depth_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_kept_q  <= 1'b0;
			left_color_q <= '0;
		end else if (ent_we) begin
			if (end_row_s1) begin
				left_kept_q  <= 1'b0;
				left_color_q <= '0;
			end else begin
				left_kept_q  <= kept_new;
				left_color_q <= color_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= s1_fire && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = s2_valid_q;
	assign m_axis_tuser  = res_s2.kept;
	assign m_axis_tlast  = res_s2.last_vertex;
	assign m_axis_tdata  = {6'b0, res_s2.tall_y, res_s2.wide_x, res_s2.sh_blue,
		res_s2.sh_green, res_s2.sh_red, res_s2.pos_z, res_s2.pos_y_half,
		res_s2.pos_x_half};

endmodule

FILE: src/p2s_checker.sv
// Port-level checks on the coalescer result stream, bound to the top level.
// Depends on p2s_pkg and the assertion macro header.
`include "pixel_to_splat_coalescer_unit_defines.svh"

module p2s_checker
	import p2s_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser,
	input logic                   m_axis_tlast
);

	// a stalled record keeps its contents
	`P2S_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// dropped vertices never carry a doubled scale
	`P2S_ASSERT_NOW(a_drop_no_scale, clk, arst_n, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[72] && !m_axis_tdata[73])

	// half-step offsets follow the scale flags
	`P2S_ASSERT_NOW(a_x_offset, clk, arst_n, m_axis_tvalid, m_axis_tdata[0] == m_axis_tdata[72])
	`P2S_ASSERT_NOW(a_y_offset, clk, arst_n, m_axis_tvalid, m_axis_tdata[11] == m_axis_tdata[73])

	// the final record is a bottom-row flush record, never y-stretched
	`P2S_ASSERT_NOW(a_last_flat, clk, arst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[73])

endmodule

bind pixel_to_splat_coalescer_unit p2s_checker u_p2s_checker (.*);

FILE: tb/sv/splat_tracker_pkg.sv
// Splat record predictor and scoreboard for the pixel-to-splat coalescer bench.
// Depends on p2s_pkg for the result layout and port widths.
package splat_tracker_pkg;
	import p2s_pkg::*;

	localparam int unsigned LINE_DEPTH  = 1024;
	localparam longint      DC_GAIN_Q24 = 64'd477655299;

	class splat_tracker;
		bit [10:0]   width_reg  = 11'd1024;
		bit [10:0]   height_reg = 11'd1024;
		bit          depth_on   = 1'b0;
		bit [23:0]   line_color [LINE_DEPTH];
		bit          line_kept  [LINE_DEPTH];
		bit [7:0]    line_depth [LINE_DEPTH];
		int unsigned col;
		int unsigned row;
		bit          left_kept;
		bit [23:0]   left_color;
		p2s_result_t pending_splats[$];
		int unsigned failures;

		function int unsigned eff_dim(bit [10:0] v);
			if (v == 0) return 1;
			if (v > LINE_DEPTH) return LINE_DEPTH;
			return v;
		endfunction

		// (c/255 - 0.5) * 2 * sqrt(pi) in Q.12, rounded half away (never ties)
		function logic signed [13:0] sh_term(bit [7:0] c);
			longint m;
			longint q;
			m = 2 * longint'(c) - 255;
			q = ((m < 0 ? -m : m) * DC_GAIN_Q24 + 64'd8388608) >>> 24;
			if (m < 0) q = -q;
			return 14'(q);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) $display("%s", msg);
		endfunction

		function void emit_splat(int unsigned x, int unsigned yrow, bit tall, bit last);
			p2s_result_t s;
			bit [23:0]   c;
			bit          merge;
			bit          wide;
			bit          t;
			c = line_color[x];
			merge = line_kept[x] && !depth_on;
			wide = merge && (x + 1 < eff_dim(width_reg)) && line_color[x + 1] == c;
			t = merge && tall;
			s.pos_x_half  = 11'(2 * x + wide);
			s.pos_y_half  = 11'(2 * yrow + t);
			s.pos_z       = depth_on ? line_depth[x] : 8'd0;
			s.sh_red      = sh_term(c[23:16]);
			s.sh_green    = sh_term(c[15:8]);
			s.sh_blue     = sh_term(c[7:0]);
			s.wide_x      = wide;
			s.tall_y      = t;
			s.kept        = line_kept[x];
			s.last_vertex = last;
			pending_splats.push_back(s);
		endfunction

		// word layout: red [7:0], green [15:8], blue [23:16], depth [31:24]
		function void take_item(bit flush, bit [31:0] word);
			int unsigned w;
			int unsigned h;
			int unsigned x;
			bit          row_end;
			bit [23:0]   cur;
			bit          top_hit;
			bit          keep;
			w = eff_dim(width_reg);
			h = eff_dim(height_reg);
			x = col;
			row_end = (x + 1 >= w);
			if (!flush) begin
				if (row >= h) return;
				cur = {word[7:0], word[15:8], word[23:16]};
				top_hit = row > 0 && line_kept[x] && line_color[x] == cur;
				if (row > 0) emit_splat(x, row - 1, line_color[x] == cur, 1'b0);
				keep = depth_on || !((left_kept && left_color == cur) || top_hit);
				line_color[x] = cur;
				line_kept[x]  = keep;
				line_depth[x] = word[31:24];
				if (row_end) begin
					col = 0;
					row++;
					left_kept = 0;
					left_color = '0;
				end else begin
					col = x + 1;
					left_kept = keep;
					left_color = cur;
				end
				return;
			end
			if (row < h) return;
			emit_splat(x, h - 1, 1'b0, row_end);
			if (row_end) begin
				col = 0;
				row = 0;
				left_kept = 0;
				left_color = '0;
			end else begin
				col = x + 1;
			end
		endfunction

		function void check_splat(logic [OUT_TDATA_W-1:0] data, logic kept_bit, logic last_bit);
			p2s_result_t got;
			p2s_result_t want;
			string       bad;
			got = p2s_result_t'({last_bit, kept_bit, data[73:0]});
			if (pending_splats.size() == 0) begin
				flag($sformatf("unexpected splat record %h", got));
				return;
			end
			want = pending_splats.pop_front();
			bad = "";
			if (got.pos_x_half !== want.pos_x_half) bad = {bad, " pos_x_half"};
			if (got.pos_y_half !== want.pos_y_half) bad = {bad, " pos_y_half"};
			if (got.pos_z !== want.pos_z) bad = {bad, " pos_z"};
			if (got.sh_red !== want.sh_red) bad = {bad, " sh_red"};
			if (got.sh_green !== want.sh_green) bad = {bad, " sh_green"};
			if (got.sh_blue !== want.sh_blue) bad = {bad, " sh_blue"};
			if (got.wide_x !== want.wide_x) bad = {bad, " wide_x"};
			if (got.tall_y !== want.tall_y) bad = {bad, " tall_y"};
			if (got.kept !== want.kept) bad = {bad, " kept"};
			if (got.last_vertex !== want.last_vertex) bad = {bad, " last_vertex"};
			if (bad != "")
				flag($sformatf("splat mismatch on%s: expected %h, got %h", bad, want, got));
		endfunction
	endclass

endpackage

FILE: tb/sv/tb_top.sv
// Bench top for pixel_to_splat_coalescer_unit: directed and random frames over APB config.
// Depends on p2s_pkg and splat_tracker_pkg; records are checked against the tracker.
module tb_top;
	import p2s_pkg::*;
	import splat_tracker_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   psel          = 1'b0;
	logic                   penable       = 1'b0;
	logic                   pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr         = '0;
	logic [APB_DATA_W-1:0]  pwdata        = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	splat_tracker tracker = new();
	bit           calm = 1'b0;
	bit           held_once = 1'b0;
	int unsigned  fed = 0;

	pixel_to_splat_coalescer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit [31:0] px(bit [23:0] rgb, bit [7:0] d);
		return {d, rgb[7:0], rgb[15:8], rgb[23:16]};
	endfunction

	// all tasks enter and leave on a falling edge
	task automatic push_item(bit flush, bit [31:0] word);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= flush;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_item(flush, word);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_splats.size() != 0) @(negedge clk);
	endtask

	task automatic apb_write(bit [APB_ADDR_W-1:0] addr, bit [10:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic write_config(bit [10:0] w, bit [10:0] h, bit d);
		wait_drained();
		repeat (8) @(negedge clk);
		apb_write(REG_FRAME_WIDTH, w);
		apb_write(REG_FRAME_HEIGHT, h);
		apb_write(REG_USE_DEPTH, 11'(d));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.width_reg = w;
		tracker.height_reg = h;
		tracker.depth_on = d;
	endtask

	// pixels of one frame, then the flush items; stray items are dropped by the block
	task automatic send_frame(bit [31:0] pix[$], int unsigned noise_pct);
		int unsigned w;
		int unsigned h;
		w = tracker.eff_dim(tracker.width_reg);
		h = tracker.eff_dim(tracker.height_reg);
		for (int unsigned i = 0; i < w * h; i++) begin
			if ((i == 2 * w && !held_once) || $urandom_range(0, 149) == 0) begin
				wait_drained();
				held_once = 1'b1;
			end
			if ($urandom_range(0, 99) < noise_pct) push_item(1'b1, $urandom);
			push_item(1'b0, pix[i]);
		end
		if (noise_pct > 0) push_item(1'b0, $urandom);
		for (int unsigned x = 0; x < w; x++) begin
			if (x > 0 && $urandom_range(0, 99) < noise_pct) push_item(1'b0, $urandom);
			push_item(1'b1, $urandom);
		end
	endtask

	task automatic random_frame(bit [10:0] wr, bit [10:0] hr, bit dep, int unsigned noise_pct);
		bit [23:0]   pal [4];
		bit [31:0]   pix [$];
		int unsigned npal;
		int unsigned n;
		npal = $urandom_range(1, 4);
		foreach (pal[k]) begin
			case ($urandom_range(0, 7))
				0: pal[k] = 24'h000000;
				1: pal[k] = 24'hffffff;
				default: pal[k] = 24'($urandom);
			endcase
		end
		write_config(wr, hr, dep);
		n = tracker.eff_dim(wr) * tracker.eff_dim(hr);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 85)
				pix.push_back(px(pal[$urandom_range(0, npal - 1)], 8'($urandom)));
			else
				pix.push_back(px(24'($urandom), 8'($urandom)));
		end
		send_frame(pix, noise_pct);
		fed += n + tracker.eff_dim(wr);
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				tracker.check_splat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		bit [31:0] pix [$];
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3: left and top drops, wide and tall merges, color extremes, stray items
		write_config(11'd3, 11'd3, 1'b0);
		push_item(1'b1, 32'hffffffff);
		pix = '{px(24'h000000, 8'h00), px(24'h000000, 8'hff), px(24'hffffff, 8'h01),
			px(24'h000000, 8'h80), px(24'h7f80ff, 8'h7f), px(24'hffffff, 8'hfe),
			px(24'h80007f, 8'h55), px(24'h80007f, 8'haa), px(24'h80007f, 8'h00)};
		send_frame(pix, 8);

		// depth mode: equal colors stay kept, z from the depth byte
		write_config(11'd2, 11'd2, 1'b1);
		pix = '{px(24'h123456, 8'h00), px(24'h123456, 8'hff),
			px(24'h123456, 8'h80), px(24'hfedcba, 8'h7f)};
		send_frame(pix, 0);

		// zero registers clamp to a single pixel frame
		write_config(11'd0, 11'd0, 1'b0);
		pix = '{px(24'hff00ff, 8'haa)};
		send_frame(pix, 0);

		while (fed < 900) begin
			calm = ($urandom_range(0, 5) == 0);
			random_frame(($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 64))
				: 11'($urandom_range(1, 12)), 11'($urandom_range(1, 5)),
				$urandom_range(0, 3) == 0, 6);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.pending_splats.size() != 0)
			tracker.flag($sformatf("%0d splat records never came, first %h",
				tracker.pending_splats.size(), tracker.pending_splats[0]));
		if (tracker.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
